// ===== src/rrpt_pkg.sv =====
// Package for the resistance-ratio polynomial temperature converter.
// Holds the shared status codes, widths and controller-to-datapath command types.
// No dependencies.
package rrpt_pkg;

    localparam int ROW_WORDS    = 8;
    localparam int NOMINAL_WORD = 7;
    localparam int TOP_COEF     = 6;
    localparam int WORD_W       = 32;
    localparam int SAMPLE_W     = 24;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NONPOS = 2'd1,
        ST_SAT    = 2'd2,
        ST_LOAD   = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;   // latch the request fields
        logic       rd_en;     // read a table word
        logic [2:0] rd_word;   // which word of the row
        logic       ratio_ld;  // take the nominal word and start the divider
        logic       div_step;  // one quotient bit
        logic       ratio_fin; // saturate the quotient into p
        logic       acc_ld;    // load the accumulator from read data
        logic       mul_go;    // register the Horner product
        logic       add_go;    // floor, add coefficient, saturate
        logic       scl_go;    // register acc * SCALE
        logic       fin_go;    // form result and strobe it
    } dp_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic is_load;
        logic nonpos;
    } dp_stat_t;

endpackage

// ===== src/rrpt_datapath.sv =====
// Datapath of the converter: coefficient memory, serial divider,
// Horner multiply-add unit and output register. Depends on rrpt_pkg.
module rrpt_datapath #(
    parameter int CHANNELS = 8,
    parameter int SCALE    = 100
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     command,
    input  logic [2:0]               channel,
    input  logic [2:0]               word_index,
    input  logic signed [31:0]       word_value,
    input  logic signed [23:0]       sample,
    input  rrpt_pkg::dp_cmd_t        cmd,
    output rrpt_pkg::dp_stat_t       stat,
    output logic [2:0]               channel_out,
    output logic [31:0]              temperature_scaled,
    output logic [1:0]               status,
    output logic                     done
);
    import rrpt_pkg::*;

    localparam int DEPTH  = CHANNELS * ROW_WORDS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [2:0]          ch_reg;
    logic [2:0]          idx_reg;
    logic [31:0]         val_reg;
    logic [23:0]         smp_reg;
    logic                load_reg;
    logic                valid_ch;
    logic [DEPTH-1:0]    vld_reg;
    logic [31:0]         mem [DEPTH];
    logic [31:0]         rd_reg;
    logic                rd_vld_reg;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   wr_addr;
    logic signed [31:0]  rd_word;

    // Dividend holds R*SCALE*2^8 (up to 56 bits); remainder fits 25 bits.
    logic [55:0]         dvd_reg;
    logic [24:0]         rem_reg;
    logic                neg_num_reg;
    logic [31:0]         p_reg;
    logic                sat_reg;
    logic signed [31:0]  acc_reg;
    logic [63:0]         mag_reg;
    logic                mneg_reg;
    logic signed [63:0]  prod_reg;
    logic [2:0]          ch_o_reg;
    logic [31:0]         t_o_reg;
    logic [1:0]          st_o_reg;
    logic                done_reg;

    logic signed [47:0]  num_wide;
    logic [25:0]         rem_sh;
    logic [25:0]         rem_sub;
    logic [31:0]         acc_mag;
    logic signed [40:0]  floor_val;
    logic signed [41:0]  sum_val;

    assign valid_ch = ({2'b00, ch_reg} < 5'(CHANNELS));
    assign rd_addr  = ADDR_W'({ch_reg, cmd.rd_word});
    assign wr_addr  = ADDR_W'({ch_reg, idx_reg});
    assign rd_word  = rd_vld_reg ? $signed(rd_reg) : 32'sd0;
    assign stat.is_load = load_reg;
    assign stat.nonpos  = (smp_reg[23] == 1'b1) || (smp_reg == 24'd0);

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ch_reg   <= channel;
            idx_reg  <= word_index;
            val_reg  <= word_value;
            smp_reg  <= sample;
            load_reg <= command;
        end
    end

    // Coefficient memory with registered read and per-entry valid bits.
    always_ff @(posedge clk)
    begin
        if (load_reg && cmd.fin_go && valid_ch)
            mem[wr_addr] <= val_reg;
        if (cmd.rd_en)
            rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (load_reg && cmd.fin_go && valid_ch)
                vld_reg[wr_addr] <= 1'b1;
            if (cmd.rd_en)
                rd_vld_reg <= valid_ch && vld_reg[rd_addr];
        end
    end

    // Restoring divider, one quotient bit per step.
    assign num_wide = 48'(rd_word) * 48'(SCALE);
    assign rem_sh   = {rem_reg, dvd_reg[55]};
    assign rem_sub  = rem_sh - {2'b00, smp_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.ratio_ld)
        begin
            neg_num_reg <= num_wide[47];
            dvd_reg     <= {num_wide, 8'd0};
            rem_reg     <= '0;
            sat_reg     <= 1'b0;
        end
        else if (cmd.div_step)
        begin
            if (!rem_sub[25])
            begin
                rem_reg <= rem_sub[24:0];
                dvd_reg <= {dvd_reg[54:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[24:0];
                dvd_reg <= {dvd_reg[54:0], 1'b0};
            end
        end
        else if (cmd.ratio_fin)
        begin
            if (neg_num_reg)
            begin
                p_reg   <= '0;
                sat_reg <= 1'b1;
            end
            else if (dvd_reg[55:32] != 24'd0)
            begin
                p_reg   <= '1;
                sat_reg <= 1'b1;
            end
            else
                p_reg <= dvd_reg[31:0];
        end
        else if (cmd.add_go && (sum_val > 42'sd2147483647 || sum_val < -42'sd2147483648))
            sat_reg <= 1'b1;
    end

    // Horner step: register |acc|*p, then floor, add and saturate.
    assign acc_mag   = acc_reg[31] ? 32'(-acc_reg) : 32'(acc_reg);
    assign floor_val = mneg_reg ? -$signed({1'b0, 40'((mag_reg + 64'hFFFFFF) >> 24)})
                                : $signed({1'b0, mag_reg[63:24]});
    assign sum_val   = 42'(floor_val) + 42'(rd_word);

    always_ff @(posedge clk)
    begin
        if (cmd.acc_ld)
            acc_reg <= rd_word;
        else if (cmd.mul_go)
        begin
            mag_reg  <= 64'(acc_mag) * 64'(p_reg);
            mneg_reg <= acc_reg[31];
        end
        else if (cmd.add_go)
        begin
            if (sum_val > 42'sd2147483647)
                acc_reg <= 32'sh7FFFFFFF;
            else if (sum_val < -42'sd2147483648)
                acc_reg <= 32'sh80000000;
            else
                acc_reg <= 32'(sum_val);
        end
        if (cmd.scl_go)
            prod_reg <= 64'(acc_reg) * 64'(SCALE);
    end

    // Output register and strobe.
    always_ff @(posedge clk)
    begin
        if (cmd.fin_go)
        begin
            ch_o_reg <= ch_reg;
            if (load_reg)
            begin
                t_o_reg  <= '0;
                st_o_reg <= ST_LOAD;
            end
            else if (stat.nonpos)
            begin
                t_o_reg  <= '0;
                st_o_reg <= ST_NONPOS;
            end
            else if (!prod_reg[63])
            begin
                t_o_reg  <= prod_reg[47:16];
                st_o_reg <= sat_reg ? ST_SAT : ST_OK;
            end
            else if ((64'(-prod_reg) >> 16) != 64'd0)
            begin
                t_o_reg  <= '0;
                st_o_reg <= ST_SAT;
            end
            else
            begin
                t_o_reg  <= '0;
                st_o_reg <= sat_reg ? ST_SAT : ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.fin_go;
    end

    assign channel_out        = ch_o_reg;
    assign temperature_scaled = t_o_reg;
    assign status             = st_o_reg;
    assign done               = done_reg;

endmodule

// ===== src/rrpt_ctrl.sv =====
// Controller state machine: sequences the read, divide, Horner and output
// steps of one request. Depends on rrpt_pkg.
module rrpt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  rrpt_pkg::dp_stat_t  stat,
    output rrpt_pkg::dp_cmd_t   cmd,
    output logic                busy
);
    import rrpt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RDNOM, S_RATIO, S_DIV, S_RFIN, S_RDTOP, S_ACCLD,
        S_MUL, S_ADD, S_SCL, S_FIN
    } state_t;

    state_t      state_reg;
    logic [5:0]  cnt_reg;
    logic [2:0]  coef_reg;
    logic        busy_reg;

    // Combinational command decode from the current state.
    always_comb
    begin
        cmd          = '0;
        cmd.capture  = start && !busy_reg;
        case (state_reg)
            S_RDNOM:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_word = 3'(NOMINAL_WORD);
            end
            S_RATIO:  cmd.ratio_ld  = 1'b1;
            S_DIV:    cmd.div_step  = 1'b1;
            S_RFIN:
            begin
                cmd.ratio_fin = 1'b1;
                cmd.rd_en     = 1'b1;
                cmd.rd_word   = 3'(TOP_COEF);
            end
            S_ACCLD:  cmd.acc_ld = 1'b1;
            S_MUL:
            begin
                cmd.mul_go  = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_word = coef_reg;
            end
            S_ADD:    cmd.add_go = 1'b1;
            S_SCL:    cmd.scl_go = 1'b1;
            S_FIN:    cmd.fin_go = 1'b1;
            default:  ;
        endcase
    end

    // State register and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            coef_reg  <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (start)
                    begin
                        state_reg <= S_DECODE;
                        busy_reg  <= 1'b1;
                    end
                S_DECODE:
                    if (stat.is_load || stat.nonpos)
                        state_reg <= S_FIN;
                    else
                        state_reg <= S_RDNOM;
                S_RDNOM:  state_reg <= S_RATIO;
                S_RATIO:
                begin
                    state_reg <= S_DIV;
                    cnt_reg   <= 6'd55;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                        state_reg <= S_RFIN;
                end
                S_RFIN:   state_reg <= S_ACCLD;
                S_ACCLD:
                begin
                    state_reg <= S_MUL;
                    coef_reg  <= 3'(TOP_COEF - 1);
                end
                S_MUL:    state_reg <= S_ADD;
                S_ADD:
                begin
                    coef_reg <= coef_reg - 3'd1;
                    if (coef_reg == 3'd0)
                        state_reg <= S_SCL;
                    else
                        state_reg <= S_MUL;
                end
                S_SCL:    state_reg <= S_FIN;
                S_FIN:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = busy_reg;

endmodule

// ===== src/resistance_ratio_poly_temperature.sv =====
// Top level of the resistance-ratio polynomial temperature converter.
// Instantiates rrpt_ctrl and rrpt_datapath; depends on rrpt_pkg.
//
//  channel   | direction | handshake           | fields
//  request   | in        | start, busy         | command, channel, word_index,
//            |           |                     | word_value, sample
//  result    | out       | done (one cycle)    | channel_out, temperature_scaled,
//            |           |                     | status
//
// A convert runs from acceptance through the bit-serial divider forming the
// ratio, the six Horner multiply-add steps, scaling and the output step; a load
// or a nonpositive sample goes from decode straight to the output step. Reset
// clears the table to zero at once through per-entry valid bits. The receiver
// cannot stall; busy holds new requests off until the result has been strobed.
module resistance_ratio_poly_temperature #(
    parameter int CHANNELS = 8,
    parameter int SCALE    = 100
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               command,
    input  logic [2:0]         channel,
    input  logic [2:0]         word_index,
    input  logic signed [31:0] word_value,
    input  logic signed [23:0] sample,
    output logic               done,
    output logic [2:0]         channel_out,
    output logic [31:0]        temperature_scaled,
    output logic [1:0]         status
);
    import rrpt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rrpt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    rrpt_datapath #(
        .CHANNELS (CHANNELS),
        .SCALE    (SCALE)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .command            (command),
        .channel            (channel),
        .word_index         (word_index),
        .word_value         (word_value),
        .sample             (sample),
        .cmd                (cmd),
        .stat               (stat),
        .channel_out        (channel_out),
        .temperature_scaled (temperature_scaled),
        .status             (status),
        .done               (done)
    );

endmodule
